// ===== src/cntts_pkg.sv =====
// Shared types, constants and the note frequency table for the tone step unit.
package cntts_pkg;

  // Field widths
  localparam int VoiceW = 2;
  localparam int WordW  = 13;
  localparam int ByteW  = 8;
  localparam int DurW   = 5;
  localparam int FreqW  = 16;

  // Voice code that carries no voice
  localparam logic [VoiceW-1:0] VoiceNone = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] RegWaveVoice0 = 2'd0;
  localparam logic [1:0] RegWaveVoice1 = 2'd1;
  localparam logic [1:0] RegWaveVoice2 = 2'd2;

  // Waveform byte reset values
  localparam logic [ByteW-1:0] WaveVoice0Rst = 8'd17;
  localparam logic [ByteW-1:0] WaveVoice1Rst = 8'd65;
  localparam logic [ByteW-1:0] WaveVoice2Rst = 8'd33;

  // Controller states
  typedef enum logic {
    StIdle,
    StEmit
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture the incoming word
    logic advance;  // a step transfer completes
  } cntts_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic item_has_steps;  // incoming word produces at least one step
    logic last;            // current step is the final one of the note
  } cntts_status_t;

  // Top octave frequency word of each scale note
  function automatic logic [FreqW-1:0] base_freq(input logic [3:0] note);
    logic [FreqW-1:0] f;
    unique case (note)
      4'd0:    f = 16'd34334;
      4'd1:    f = 16'd36376;
      4'd2:    f = 16'd38539;
      4'd3:    f = 16'd40830;
      4'd4:    f = 16'd43258;
      4'd5:    f = 16'd45830;
      4'd6:    f = 16'd48556;
      4'd7:    f = 16'd51443;
      4'd8:    f = 16'd54502;
      4'd9:    f = 16'd57743;
      4'd10:   f = 16'd61176;
      4'd11:   f = 16'd64814;
      default: f = 16'd0;  // past the scale: no tone
    endcase
    return f;
  endfunction

endpackage

// ===== src/coded_note_to_tone_steps_unit.sv =====
// Top level of the coded note to tone step unit.
// The first step is shown in the cycle after the word's transfer.
// Throughput: one step per cycle without stall; a word yields max(duration,1)
// steps, an end marker or voice 3 none, and no new word is taken meanwhile.
// The step count is set by the single countdown counter in the datapath.
// Reset: step counters clear to zero, waveform bytes take their defaults.
module coded_note_to_tone_steps_unit #(
  parameter int STEPS_PER_VOICE = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [cntts_pkg::VoiceW-1:0]       voice_i,
  input  logic signed [cntts_pkg::WordW-1:0] coded_note_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [cntts_pkg::VoiceW-1:0]       out_voice_o,
  output logic [cntts_pkg::ByteW-1:0]        step_position_o,
  output logic [cntts_pkg::ByteW-1:0]        freq_high_o,
  output logic [cntts_pkg::ByteW-1:0]        freq_low_o,
  output logic [cntts_pkg::ByteW-1:0]        control_o,
  output logic                               last_step_o,
  output logic                               overflow_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [1:0]                         cfg_index_i,
  input  logic [cntts_pkg::ByteW-1:0]        cfg_data_i
);
  import cntts_pkg::*;

  cntts_cmd_t    cmd;
  cntts_status_t status;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  cntts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cntts_datapath #(
    .STEPS_PER_VOICE (STEPS_PER_VOICE)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .voice_i         (voice_i),
    .coded_note_i    (coded_note_i),
    .cfg_write_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_voice_o     (out_voice_o),
    .step_position_o (step_position_o),
    .freq_high_o     (freq_high_o),
    .freq_low_o      (freq_low_o),
    .control_o       (control_o),
    .last_step_o     (last_step_o),
    .overflow_o      (overflow_o)
  );

endmodule

// ===== src/cntts_ctrl.sv =====
// Controller state machine: takes a word, then walks its steps out.
module cntts_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  input  cntts_pkg::cntts_status_t status_i,
  output cntts_pkg::cntts_cmd_t    cmd_o
);
  import cntts_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
        if (in_valid_i && status_i.item_has_steps) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        out_valid_o   = 1'b1;
        cmd_o.advance = !out_stall_i;
        if (!out_stall_i && status_i.last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// ===== src/cntts_datapath.sv =====
// Datapath: note decode, waveform registers, per-voice step counters, step fields.
module cntts_datapath #(
  parameter int STEPS_PER_VOICE = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cntts_pkg::cntts_cmd_t          cmd_i,
  output cntts_pkg::cntts_status_t       status_o,
  input  logic [cntts_pkg::VoiceW-1:0]  voice_i,
  input  logic signed [cntts_pkg::WordW-1:0] coded_note_i,
  input  logic                          cfg_write_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [cntts_pkg::ByteW-1:0]   cfg_data_i,
  output logic [cntts_pkg::VoiceW-1:0]  out_voice_o,
  output logic [cntts_pkg::ByteW-1:0]   step_position_o,
  output logic [cntts_pkg::ByteW-1:0]   freq_high_o,
  output logic [cntts_pkg::ByteW-1:0]   freq_low_o,
  output logic [cntts_pkg::ByteW-1:0]   control_o,
  output logic                          last_step_o,
  output logic                          overflow_o
);
  import cntts_pkg::*;

  localparam int PosLimit = (STEPS_PER_VOICE > 256) ? 255 : STEPS_PER_VOICE - 1;
  localparam int CntW     = $clog2(PosLimit + 2);
  localparam logic [CntW-1:0] PosLimitC = CntW'(PosLimit);

  logic [ByteW-1:0] wave_q [3];
  logic [CntW-1:0]  pos_q  [3];

  logic [VoiceW-1:0] voice_q;
  logic [FreqW-1:0]  freq_q;
  logic [ByteW-1:0]  on_ctrl_q, last_ctrl_q;
  logic [DurW-1:0]   remain_q;

  // Decode the incoming word
  logic [WordW-1:0] word, neg_word;
  logic [11:0]      mag;
  logic             silence;
  logic [DurW-1:0]  dur;
  logic [2:0]       oct;
  logic [3:0]       note;
  logic [ByteW-1:0] wave_sel, on_ctrl_d, off_ctrl_d;
  logic [FreqW-1:0] freq_d;

  always_comb begin
    word       = coded_note_i;
    neg_word   = WordW'(0) - word;
    silence    = word[WordW-1];
    mag        = silence ? neg_word[11:0] : word[11:0];
    dur        = mag[11:7];
    oct        = mag[6:4];
    note       = mag[3:0];
    freq_d     = base_freq(note) >> (3'd7 - oct);
    wave_sel   = (voice_i == VoiceNone) ? '0 : wave_q[voice_i];
    on_ctrl_d  = silence ? '0 : wave_sel;
    off_ctrl_d = silence ? '0 : wave_sel - 8'd1;
  end

  assign status_o.item_has_steps = (voice_i != VoiceNone) && (word != '0);
  assign status_o.last           = (remain_q == DurW'(1));

  // Waveform registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q[0] <= WaveVoice0Rst;
      wave_q[1] <= WaveVoice1Rst;
      wave_q[2] <= WaveVoice2Rst;
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        RegWaveVoice0: wave_q[0] <= cfg_data_i;
        RegWaveVoice1: wave_q[1] <= cfg_data_i;
        RegWaveVoice2: wave_q[2] <= cfg_data_i;
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Capture the note; count down the steps left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
    end else if (cmd_i.load) begin
      remain_q <= (dur == '0) ? DurW'(1) : dur;
    end else if (cmd_i.advance) begin
      remain_q <= remain_q - DurW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      voice_q     <= voice_i;
      freq_q      <= freq_d;
      on_ctrl_q   <= on_ctrl_d;
      last_ctrl_q <= (dur == DurW'(1)) ? on_ctrl_d : off_ctrl_d;
    end
  end

  // Step position of the current voice, saturating one past the limit
  logic [CntW-1:0] cnt_cur, pos_sel;
  logic            ovf;

  always_comb begin
    cnt_cur = (voice_q == VoiceNone) ? '0 : pos_q[voice_q];
    ovf     = cnt_cur > PosLimitC;
    pos_sel = ovf ? PosLimitC : cnt_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0] <= '0;
      pos_q[1] <= '0;
      pos_q[2] <= '0;
    end else if (cmd_i.advance && !ovf && voice_q != VoiceNone) begin
      pos_q[voice_q] <= cnt_cur + CntW'(1);
    end
  end

  // Step fields
  assign out_voice_o     = voice_q;
  assign step_position_o = ByteW'(pos_sel);
  assign freq_high_o     = freq_q[15:8];
  assign freq_low_o      = freq_q[7:0];
  assign control_o       = status_o.last ? last_ctrl_q : on_ctrl_q;
  assign last_step_o     = status_o.last;
  assign overflow_o      = ovf;

endmodule

// ===== src/cntts_checker.sv =====
// Port checker for the tone step unit and its bind to the top level.
module cntts_checker #(
  parameter int STEPS_PER_VOICE = 256
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [cntts_pkg::VoiceW-1:0]       out_voice_o,
  input logic [cntts_pkg::ByteW-1:0]        step_position_o,
  input logic [cntts_pkg::ByteW-1:0]        freq_high_o,
  input logic [cntts_pkg::ByteW-1:0]        freq_low_o,
  input logic [cntts_pkg::ByteW-1:0]        control_o,
  input logic                               last_step_o,
  input logic                               overflow_o
);
  import cntts_pkg::*;

  localparam int PosLimit = (STEPS_PER_VOICE > 256) ? 255 : STEPS_PER_VOICE - 1;
  localparam logic [ByteW-1:0] PosLimitB = ByteW'(PosLimit);

  // Hold a stalled step
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("step dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(step_position_o) && $stable(control_o)
      && $stable(last_step_o) && $stable(freq_high_o) && $stable(freq_low_o))
    else $error("stalled step changed");

  // No new word while steps of the last one are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("word taken while steps pending");

  // Saturated steps sit at the limit
  a_ovf_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> step_position_o == PosLimitB)
    else $error("overflow step off the limit");

  // Steps only ever belong to voices 0 to 2
  a_no_voice3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_voice_o != VoiceNone)
    else $error("step for an unused voice");

endmodule

bind coded_note_to_tone_steps_unit cntts_checker #(
  .STEPS_PER_VOICE (STEPS_PER_VOICE)
) u_cntts_checker (.*);
